@@ rtl/core/ils_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ils_pkg
// Shared types and constants for the indexed list store.
// ----------------------------------------------------------------------------
package ils_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int POS_W    = 8;
   localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int LEN_W    = 7;

   // request codes
   localparam logic [2:0] REQ_READ   = 3'd0;
   localparam logic [2:0] REQ_FRONT  = 3'd1;
   localparam logic [2:0] REQ_APPEND = 3'd2;
   localparam logic [2:0] REQ_INSERT = 3'd3;
   localparam logic [2:0] REQ_DELETE = 3'd4;

   // status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_RANGE = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   typedef struct packed {
      logic [2:0]         req_type;
      logic [POS_W-1:0]   position;
      logic signed [31:0] item_value;
   } ils_req_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic [1:0]         status;
      logic [LEN_W-1:0]   list_length;
   } ils_rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_SHIFT,
      S_FILL,
      S_FINISH
   } ils_state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;        // latch the accepted request
      logic rd_pos;      // read memory at the request position
      logic cur_init;    // start the shift cursor
      logic shift_step;  // move one entry
      logic fill;        // write the inserted value
      logic finish;      // update the length and load the response
   } ils_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_read;
      logic is_ins;
      logic is_del;
      logic req_ok;
      logic shift_more;
      logic rsp_free;
   } ils_sts_type;

endpackage
`default_nettype wire

@@ rtl/core/indexed_list_store_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_list_store_top
// Bounded ordered list of signed 32-bit values with read, insert and delete.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready/req_data) carries one operation:
//   read, insert front, append, insert at index, or delete at index.
//   Response channel (rsp_valid/rsp_ready/rsp_data) returns exactly one
//   result per request: read value (-1 unless a good read), status
//   (ok / index out of range / store full) and the length afterwards.
//   Insert and delete move one entry per cycle through the two-port
//   entry memory (one read, one write per cycle), so the worst case is set
//   by CAPACITY. One request is in work at a time; the sequencer returns
//   to idle after loading a response.
//   req_ready is high whenever the sequencer is idle, even while a previous
//   response still waits; on a receiver stall that response sits in its
//   output register and the next request waits at the last step.
//   Reset (synchronous, active high) empties the list and drops any pending
//   response; memory contents are not cleared and need not be.
// ----------------------------------------------------------------------------
module indexed_list_store_top
   import ils_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire ils_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output ils_rsp_type      rsp_data
);

   ils_cmd_type cmd;
   ils_sts_type sts;

   // sequencer
   ils_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // storage, cursor and response register
   ils_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

@@ rtl/core/ils_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ils_ctrl
// Sequencer for the indexed list store: decode, shift, fill, respond.
// ----------------------------------------------------------------------------
module ils_ctrl
   import ils_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire ils_sts_type sts,
   output ils_cmd_type      cmd
);

   ils_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (sts.req_ok && sts.is_read) begin
               cmd.rd_pos = 1'b1;
               state_in   = S_FINISH;
            end else if (sts.req_ok && (sts.is_ins || sts.is_del)) begin
               cmd.cur_init = 1'b1;
               state_in     = S_SHIFT;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_SHIFT: begin
            if (sts.shift_more) begin
               cmd.shift_step = 1'b1;
            end else if (sts.is_ins) begin
               state_in = S_FILL;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FILL: begin
            cmd.fill = 1'b1;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (sts.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

@@ rtl/core/ils_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ils_dp
// Datapath: request registers, entry memory, shift cursor, length, response.
// ----------------------------------------------------------------------------
module ils_dp
   import ils_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire ils_req_type req_data,
   input  wire ils_cmd_type cmd,
   output ils_sts_type      sts,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output ils_rsp_type      rsp_data
);

   logic [31:0]      mem [CAPACITY];

   logic [2:0]       op_ff;
   logic [CMP_W-1:0] pos_ff;
   logic [31:0]      val_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] cur_ff, cur_in;
   logic [31:0]      rdata_ff;
   logic             wv_ff;
   logic [IDX_W-1:0] wa_ff;
   logic             rsp_valid_ff;
   ils_rsp_type      rsp_ff, rsp_in;

   logic [CMP_W-1:0] count_x, cur_x, pos_in;
   logic [CNT_W:0]   cur_p1;
   logic             range_err, full_err;
   logic             rd_en;
   logic [IDX_W-1:0] raddr;

   assign count_x = CMP_W'(count_ff);
   assign cur_x   = CMP_W'(cur_ff);
   assign cur_p1  = {1'b0, cur_ff} + 1'b1;

   // request decode
   always_comb begin
      sts.is_read = (op_ff == REQ_READ);
      sts.is_ins  = (op_ff == REQ_FRONT) || (op_ff == REQ_APPEND) ||
                    (op_ff == REQ_INSERT);
      sts.is_del  = (op_ff == REQ_DELETE);
      range_err   = 1'b0;
      full_err    = 1'b0;
      if (sts.is_read || sts.is_del) begin
         range_err = (pos_ff >= count_x);
      end else if (sts.is_ins) begin
         range_err = (pos_ff > count_x);
         full_err  = !range_err && (count_ff >= CNT_W'(CAPACITY));
      end
      sts.req_ok     = !range_err && !full_err;
      sts.shift_more = sts.is_ins ? (cur_x > pos_ff)
                                  : (cur_p1 < {1'b0, count_ff});
      sts.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   // front maps to zero, append to the current length
   always_comb begin
      case (req_data.req_type)
         REQ_FRONT:  pos_in = '0;
         REQ_APPEND: pos_in = count_x;
         default:    pos_in = CMP_W'(req_data.position);
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_data.req_type;
         pos_ff <= pos_in;
         val_ff <= req_data.item_value;
      end
   end

   // shift cursor: insert walks down from the length, delete walks up
   always_comb begin
      cur_in = cur_ff;
      raddr  = pos_ff[IDX_W-1:0];
      if (cmd.cur_init) begin
         cur_in = sts.is_ins ? count_ff : pos_ff[CNT_W-1:0];
      end else if (cmd.shift_step) begin
         if (sts.is_ins) begin
            cur_in = cur_ff - 1'b1;
            raddr  = cur_in[IDX_W-1:0];
         end else begin
            cur_in = cur_p1[CNT_W-1:0];
            raddr  = cur_in[IDX_W-1:0];
         end
      end
   end

   assign rd_en = cmd.rd_pos || cmd.shift_step;

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (cmd.shift_step) begin
         wa_ff <= cur_ff[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wv_ff <= 1'b0;
      end else begin
         wv_ff <= cmd.shift_step;
      end
   end

   // entry memory: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (wv_ff) begin
         mem[wa_ff] <= rdata_ff;
      end else if (cmd.fill) begin
         mem[pos_ff[IDX_W-1:0]] <= val_ff;
      end
      if (rd_en) begin
         rdata_ff <= mem[raddr];
      end
   end

   // length and response
   always_comb begin
      count_in = count_ff;
      if (sts.req_ok && sts.is_ins) begin
         count_in = count_ff + 1'b1;
      end else if (sts.req_ok && sts.is_del) begin
         count_in = count_ff - 1'b1;
      end
      rsp_in.read_value  = (sts.req_ok && sts.is_read) ? rdata_ff : '1;
      rsp_in.status      = range_err ? STAT_RANGE : (full_err ? STAT_FULL : STAT_OK);
      rsp_in.list_length = LEN_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         count_ff     <= count_in;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

@@ rtl/core/ils_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ils_checker
// Port-level checks for the indexed list store, bound to the top level.
// ----------------------------------------------------------------------------
module ils_checker
   import ils_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire ils_rsp_type rsp_data
);

   // a pending response is held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // one request at a time: ready drops right after an accept
   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // any failed request reports -1
   a_err_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != STAT_OK) |-> (rsp_data.read_value == -32'sd1))
      else $error("error response with read value");

   // a full refusal reports a full list
   a_full_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STAT_FULL) |->
         (rsp_data.list_length == LEN_W'(CAPACITY)))
      else $error("store full with short list");

   // reset empties the response register
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind indexed_list_store_top ils_checker u_ils_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
`default_nettype wire
